// ----- src/flash_range_erase_planner_assert.svh -----
// Assertion macros for the flash range erase planner.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef FLASH_RANGE_ERASE_PLANNER_ASSERT_SVH
`define FLASH_RANGE_ERASE_PLANNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- src/fre_pkg.sv -----
// Shared types and constants of the flash range erase planner.
// No dependencies.
package fre_pkg;

    localparam int unsigned SECTOR_BYTES_DEF      = 4096;
    localparam int unsigned MAX_RANGE_SECTORS_DEF = 32;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned LEN_W    = 25;
    localparam int unsigned OPLEN_W  = 12;

    localparam int unsigned S_TDATA_W = 56;  // 24 + 25 bits, padded to bytes
    localparam int unsigned M_TDATA_W = 40;  // 24 + 12 bits, padded to bytes
    localparam int unsigned M_TUSER_W = 3;

    localparam int unsigned RESULT_LIMIT = 38;
    localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT + 1);

    // sized for the largest sector (64 KiB) and longest range (63 sectors)
    localparam int unsigned PART_W  = 16;
    localparam int unsigned WHOLE_W = 6;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SAVE    = 2'd0,
        OP_ERASE   = 2'd1,
        OP_RESTORE = 2'd2,
        OP_REJECT  = 2'd3
    } t_op_kind;

    // Classified request, handed from front to back.
    typedef struct packed {
        logic              rej;        // reject request
        logic              head;       // start is not sector aligned
        logic              one_sect;   // range ends inside the head sector
        logic [ADDR_W-1:0] addr;       // start address
        logic [ADDR_W-1:0] next_addr;  // one_sect: range end; else first whole sector
        logic [PART_W-1:0] offs;       // head bytes kept before the range
        logic [PART_W-1:0] part;       // one_sect: tail bytes kept; else partial tail bytes
        logic [WHOLE_W-1:0] whole;     // whole sectors to erase
    } t_plan;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- src/fre_front.sv -----
// Front end: accepts requests, checks them and splits them into head,
// whole-sector and tail parts. Depends on fre_pkg.
module fre_front #(
    parameter int unsigned SECTOR_BYTES      = fre_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned MAX_RANGE_SECTORS = fre_pkg::MAX_RANGE_SECTORS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [fre_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                         o_push,
    output fre_pkg::t_plan               o_plan,
    input  fre_pkg::t_q_stat             i_q_stat
);
    import fre_pkg::*;

    localparam int unsigned SECT_LOG2 = $clog2(SECTOR_BYTES);
    localparam int unsigned SECT_W1   = SECT_LOG2 + 1;
    localparam logic [LEN_W-1:0] LIMIT_BYTES = LEN_W'(MAX_RANGE_SECTORS * SECTOR_BYTES);
    localparam logic [ADDR_W+1:0] ADDR_SPAN = {2'b01, {ADDR_W{1'b0}}};

    logic              r_c_vld;
    logic [ADDR_W-1:0] r_c_addr;
    logic [LEN_W-1:0]  r_c_len;

    logic [ADDR_W+1:0]    w_sum;
    logic                 w_rej;
    logic [SECT_LOG2-1:0] w_offs;
    logic [SECT_LOG2:0]   w_remain;
    logic                 w_head;
    logic                 w_inside;
    logic [LEN_W-1:0]     w_len2;
    logic [ADDR_W-1:0]    w_base;

    assign o_s_tready = !r_c_vld || !i_q_stat.full;
    assign o_push     = r_c_vld && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_c_vld <= 1'b1;
        end else if (o_push) begin
            r_c_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_c_addr <= i_s_tdata[ADDR_W-1:0];
            r_c_len  <= i_s_tdata[ADDR_W+LEN_W-1:ADDR_W];
        end
    end

    always_comb begin
        w_sum    = {2'b00, r_c_addr} + {1'b0, r_c_len};
        w_rej    = (r_c_len == '0) || (w_sum > ADDR_SPAN) || (r_c_len > LIMIT_BYTES);
        w_offs   = r_c_addr[SECT_LOG2-1:0];
        w_remain = SECT_W1'(SECTOR_BYTES) - {1'b0, w_offs};
        w_head   = (w_offs != '0);
        w_inside = w_head && (r_c_len <= LEN_W'(w_remain));
        w_len2   = w_head ? (r_c_len - LEN_W'(w_remain)) : r_c_len;
        w_base   = r_c_addr & ~ADDR_W'(SECTOR_BYTES - 1);

        o_plan.rej      = w_rej;
        o_plan.head     = w_head;
        o_plan.one_sect = w_inside;
        o_plan.addr     = r_c_addr;
        o_plan.offs     = PART_W'(w_offs);
        if (w_inside) begin
            o_plan.next_addr = r_c_addr + r_c_len[ADDR_W-1:0];
            o_plan.part      = PART_W'(w_remain - r_c_len[SECT_LOG2:0]);
            o_plan.whole     = '0;
        end else begin
            o_plan.next_addr = w_head ? (w_base + ADDR_W'(SECTOR_BYTES)) : r_c_addr;
            o_plan.part      = PART_W'(w_len2[SECT_LOG2-1:0]);
            o_plan.whole     = WHOLE_W'(w_len2 >> SECT_LOG2);
        end
    end

endmodule

// ----- src/fre_queue.sv -----
// Short queue of classified requests between front and back.
// Depends on fre_pkg.
module fre_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fre_pkg::t_plan   i_plan,
    input  logic             i_pop,
    output fre_pkg::t_plan   o_plan,
    output fre_pkg::t_q_stat o_stat
);
    import fre_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_plan             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_plan       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_plan;
        end
    end

endmodule

// ----- src/fre_back.sv -----
// Back end: sequencer that walks one classified request and emits its operations,
// one per cycle unless stalled, into an output register. Depends on fre_pkg.
module fre_back #(
    parameter int unsigned SECTOR_BYTES = fre_pkg::SECTOR_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fre_pkg::t_plan                i_plan,
    input  fre_pkg::t_q_stat              i_q_stat,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [fre_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [fre_pkg::M_TUSER_W-1:0] o_m_tuser,
    output logic                          o_m_tlast
);
    import fre_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_REJ  = 11'b000_0000_0010,
        ST_HS0  = 11'b000_0000_0100,
        ST_HS1  = 11'b000_0000_1000,
        ST_HE   = 11'b000_0001_0000,
        ST_HR0  = 11'b000_0010_0000,
        ST_HR1  = 11'b000_0100_0000,
        ST_BODY = 11'b000_1000_0000,
        ST_TS   = 11'b001_0000_0000,
        ST_TE   = 11'b010_0000_0000,
        ST_TR   = 11'b100_0000_0000
    } t_state;

    t_state             r_st;
    t_state             n_st;
    t_state             w_nat;
    t_state             w_after_head;
    t_state             w_first;
    t_plan              r_plan;
    logic [ADDR_W-1:0]  r_cur;
    logic [WHOLE_W-1:0] r_left;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_o_vld;
    t_op_kind           r_o_kind;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [OPLEN_W-1:0] r_o_len;
    logic               r_o_slot;
    logic               r_o_last;

    t_op_kind           w_kind;
    logic [ADDR_W-1:0]  w_addr;
    logic [OPLEN_W-1:0] w_len;
    logic               w_slot;
    logic               w_last;
    logic               w_adv;
    logic               w_emit;
    logic [ADDR_W-1:0]  w_base;
    logic [PART_W:0]    w_keep;

    assign w_adv  = !r_o_vld || i_m_tready;
    assign w_emit = (r_st != ST_IDLE) && w_adv;
    assign o_pop  = (r_st == ST_IDLE) && !i_q_stat.empty;

    assign w_base = r_plan.addr & ~ADDR_W'(SECTOR_BYTES - 1);
    assign w_keep = (PART_W + 1)'(SECTOR_BYTES) - {1'b0, r_plan.part};

    always_comb begin
        if (i_plan.rej) begin
            w_first = ST_REJ;
        end else if (i_plan.head) begin
            w_first = ST_HS0;
        end else if (i_plan.whole != '0) begin
            w_first = ST_BODY;
        end else begin
            w_first = ST_TS;
        end

        if (r_plan.whole != '0) begin
            w_after_head = ST_BODY;
        end else if (r_plan.part != '0) begin
            w_after_head = ST_TS;
        end else begin
            w_after_head = ST_IDLE;
        end
    end

    // operation of the current step and the natural next step
    always_comb begin
        w_kind = OP_ERASE;
        w_addr = r_cur;
        w_len  = '0;
        w_slot = 1'b0;
        w_nat  = ST_IDLE;
        case (r_st)
            ST_REJ: begin
                w_kind = OP_REJECT;
                w_addr = r_plan.addr;
            end
            ST_HS0: begin
                w_kind = OP_SAVE;
                w_addr = w_base;
                w_len  = OPLEN_W'(r_plan.offs);
                w_nat  = (r_plan.one_sect && r_plan.part != '0) ? ST_HS1 : ST_HE;
            end
            ST_HS1: begin
                w_kind = OP_SAVE;
                w_addr = r_plan.next_addr;
                w_len  = OPLEN_W'(r_plan.part);
                w_slot = 1'b1;
                w_nat  = ST_HE;
            end
            ST_HE: begin
                w_addr = w_base;
                w_nat  = ST_HR0;
            end
            ST_HR0: begin
                w_kind = OP_RESTORE;
                w_addr = w_base;
                w_len  = OPLEN_W'(r_plan.offs);
                if (r_plan.one_sect) begin
                    w_nat = (r_plan.part != '0) ? ST_HR1 : ST_IDLE;
                end else begin
                    w_nat = w_after_head;
                end
            end
            ST_HR1: begin
                w_kind = OP_RESTORE;
                w_addr = r_plan.next_addr;
                w_len  = OPLEN_W'(r_plan.part);
                w_slot = 1'b1;
            end
            ST_BODY: begin
                if (r_left == WHOLE_W'(1)) begin
                    w_nat = (r_plan.part != '0) ? ST_TS : ST_IDLE;
                end else begin
                    w_nat = ST_BODY;
                end
            end
            ST_TS: begin
                w_kind = OP_SAVE;
                w_addr = r_cur + ADDR_W'(r_plan.part);
                w_len  = OPLEN_W'(w_keep);
                w_slot = 1'b1;
                w_nat  = ST_TE;
            end
            ST_TE: begin
                w_nat = ST_TR;
            end
            ST_TR: begin
                w_kind = OP_RESTORE;
                w_addr = r_cur + ADDR_W'(r_plan.part);
                w_len  = OPLEN_W'(w_keep);
                w_slot = 1'b1;
            end
            default: begin
                w_nat = ST_IDLE;
            end
        endcase
        // list is cut after the result limit
        w_last = (w_nat == ST_IDLE) || (r_cnt == CNT_W'(RESULT_LIMIT - 1));
        n_st   = w_last ? ST_IDLE : w_nat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_st <= w_first;
            end else if (w_emit) begin
                r_st <= n_st;
            end
            if (w_adv) begin
                r_o_vld <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_plan <= i_plan;
            r_cur  <= i_plan.next_addr;
            r_left <= i_plan.whole;
            r_cnt  <= '0;
        end else if (w_emit) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_st == ST_BODY) begin
                r_cur  <= r_cur + ADDR_W'(SECTOR_BYTES);
                r_left <= r_left - 1'b1;
            end
        end
        if (w_emit) begin
            r_o_kind <= w_kind;
            r_o_addr <= w_addr;
            r_o_len  <= w_len;
            r_o_slot <= w_slot;
            r_o_last <= w_last;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {{(M_TDATA_W - ADDR_W - OPLEN_W){1'b0}}, r_o_len, r_o_addr};
    assign o_m_tuser  = {r_o_slot, r_o_kind};
    assign o_m_tlast  = r_o_last;

endmodule

// ----- src/flash_range_erase_planner.sv -----
// Top level of the flash range erase planner: front end, request queue, back end.
// Depends on fre_pkg, fre_front, fre_queue, fre_back and the assertion header.
//
//  Channel   Dir  Bus fields (low bit first)
//  s_axis    in   tdata: start_address[23:0], range_length[48:24], zero pad to 56
//  m_axis    out  tdata: op_address[23:0], op_length[35:24], zero pad to 40
//                 tuser: op_kind[1:0], buffer_slot[2]; tlast: last_op
//
// A request is held in the input register, is classified into the queue, then
// is loaded by the back-end sequencer, which emits its operations (at most 38)
// into the output register one per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous) empties the queue and the output register.
// A stalled output holds the sequencer; the front and queue keep taking up
// to three requests meanwhile.
`include "flash_range_erase_planner_assert.svh"

module flash_range_erase_planner #(
    parameter int unsigned SECTOR_BYTES      = fre_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned MAX_RANGE_SECTORS = fre_pkg::MAX_RANGE_SECTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request: start_address[23:0], range_length[48:24]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [fre_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // operation: op_address[23:0], op_length[35:24]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [fre_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // op_kind[1:0], buffer_slot[2]
    output logic [fre_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);
    import fre_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_plan   w_front_plan;
    t_plan   w_queue_plan;
    t_q_stat w_q_stat;
    logic    w_out_rej;
    logic    w_out_erase;
    logic    w_erase_clean;

    // Front: input register and classification (reject checks, head/whole/tail split).
    fre_front #(
        .SECTOR_BYTES      (SECTOR_BYTES),
        .MAX_RANGE_SECTORS (MAX_RANGE_SECTORS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .o_push     (w_push),
        .o_plan     (w_front_plan),
        .i_q_stat   (w_q_stat)
    );

    // Queue decouples classification from the operation sequencer.
    fre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_plan  (w_front_plan),
        .i_pop   (w_pop),
        .o_plan  (w_queue_plan),
        .o_stat  (w_q_stat)
    );

    // Back: walks the plan and drives the operation stream.
    fre_back #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plan     (w_queue_plan),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

    // operation kind on the output and the erase field check
    assign w_out_rej     = o_m_axis_tvalid && (o_m_axis_tuser[1:0] == OP_REJECT);
    assign w_out_erase   = o_m_axis_tvalid && (o_m_axis_tuser[1:0] == OP_ERASE);
    assign w_erase_clean = (o_m_axis_tdata[35:24] == '0) && !o_m_axis_tuser[2];

    // a reject is always the only, hence last, operation of its request
    `FRE_ASSERT_IMP(a_reject_last, i_clk, i_rst_n, w_out_rej, o_m_axis_tlast, "reject without tlast")
    // erase carries no byte count and the head slot
    `FRE_ASSERT_IMP(a_erase_fields, i_clk, i_rst_n, w_out_erase, w_erase_clean, "erase with length")
    // never push into a full queue
    `FRE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_stat.full, "queue overflow")
    // an empty queue with no push cannot be popped in the next cycle
    `FRE_ASSERT_NXT(a_no_underflow, i_clk, i_rst_n, w_q_stat.empty && !w_push, !w_pop, "underflow")

endmodule
